// ===== design/ost_pkg.sv =====
// ----------------------------------------------------------------------------
// ost_pkg: shared types and constants
// Matrix dimension, fixed-point widths, modes and the helpers for products.
// ----------------------------------------------------------------------------
package ost_pkg;

  localparam int MaxDim  = 8;
  localparam int IdxW    = 3;
  localparam int AddrW   = 6;
  localparam int DataW   = 32;
  // rounded products reach 2^46, eight of them summed need 51 bits
  localparam int AccW    = 64;

  typedef enum logic [1:0] {
    MODE_WR_X = 2'd0,
    MODE_WR_U = 2'd1,
    MODE_RUN  = 2'd2,
    MODE_NOP  = 2'd3
  } mode_t;

  // Control that travels down the chain with one product term.
  typedef struct packed {
    logic             vld;
    logic             first;
    logic             fin;
    logic             emit;
    logic [IdxW-1:0]  row;
    logic [IdxW-1:0]  col;
    logic             lst;
  } tag_t;

  // Rounded Q15.16 product: (a*b + 2^15) >> 16, floor.
  function automatic logic signed [47:0] qround(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + 64'sd32768;
    return s[63:16];
  endfunction

  function automatic logic signed [DataW-1:0] sat32(input logic signed [AccW-1:0] v);
    if (v > AccW'(32'sh7fffffff)) begin
      return 32'sh7fffffff;
    end else if (v < -AccW'(64'sd2147483648)) begin
      return 32'sh80000000;
    end
    return v[DataW-1:0];
  endfunction

endpackage

// ===== design/ost_ram.sv =====
// ----------------------------------------------------------------------------
// ost_ram: generic single-port-write, one-read RAM
// Registered read data.
// ----------------------------------------------------------------------------
module ost_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/ost_cell.sv =====
// ----------------------------------------------------------------------------
// ost_cell: one stage of the multiply-accumulate chain
// Stage 0 registers the product, stage 1 rounds, stage 2 accumulates and saturates.
// ----------------------------------------------------------------------------
module ost_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [1:0]                     sel,
  input  ost_pkg::tag_t                  tag_in,
  input  logic signed [63:0]             din,
  output ost_pkg::tag_t                  tag_out,
  output logic signed [63:0]             dout
);
  import ost_pkg::*;

  tag_t               tag_r;
  logic signed [63:0] d_r;
  logic signed [63:0] d_nxt;

  always_comb begin
    unique case (sel)
      2'd0: d_nxt = din;
      2'd1: d_nxt = 64'(qround(din));
      default: begin
        d_nxt = tag_in.first ? din : d_r + din;
        if (tag_in.fin) begin
          d_nxt = 64'(sat32(d_nxt[AccW-1:0]));
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_in;
    end
    if (tag_in.vld) begin
      d_r <= d_nxt;
    end
  end

  assign tag_out = tag_r;
  assign dout    = d_r;
endmodule

// ===== design/orthogonal_similarity_transform.sv =====
// ----------------------------------------------------------------------------
// orthogonal_similarity_transform: U^T X U / U X U^T on Q15.16 matrices
// Loads X and U by element, then a run item computes T then the result.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  in_      | start & !busy        | in_mode in_row in_col in_value in_backward
//  out_     | out_strobe, 1 cycle  | out_row out_col out_value out_last
//  cfg_     | cfg_valid&cfg_ready  | cfg_data (size_in_use)
//
// Load items are written as they are accepted. A run item walks both products
// through one sequencer feeding a three-cell chain (product register, round,
// accumulate): one product term per cycle outside the gap between the passes,
// n^3 terms per pass; the gap lets the last T element be written before it is
// read. The last result passes the tag register and the three cells after the
// last term issues; busy stays high until the drain state after it ends.
// Synchronous active-low reset clears control; the stores are undefined until
// written. Results cannot be stalled; each has out_strobe for one cycle.
module orthogonal_similarity_transform (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_mode,
  input  logic [2:0]                  in_row,
  input  logic [2:0]                  in_col,
  input  logic signed [31:0]          in_value,
  input  logic                        in_backward,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [3:0]                  cfg_data,
  output logic                        out_strobe,
  output logic [2:0]                  out_row,
  output logic [2:0]                  out_col,
  output logic signed [31:0]          out_value,
  output logic                        out_last
);
  import ost_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [3:0]       size_r;
  logic [IdxW-1:0]  n1;          // n - 1
  logic             pass_r;      // 0: T product, 1: result product
  logic             bwd_r;
  logic [IdxW-1:0]  i_r, j_r, k_r;
  logic [3:0]       drain_r;
  logic [2:0]       gap_r;       // idle cycles left before pass 1 issues
  logic             stall;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 4'd8;
    end else if (cfg_valid) begin
      size_r <= cfg_data;
    end
  end
  always_comb begin
    if (size_r == 4'd0) begin
      n1 = '0;
    end else if (size_r > 4'(MaxDim)) begin
      n1 = IdxW'(MaxDim - 1);
    end else begin
      n1 = IdxW'(size_r - 4'd1);
    end
  end

  wire accept = start && !busy;
  assign busy = (state_r != ST_IDLE);

  // Address generation for the term (i,j,k) of the active pass.
  logic [AddrW-1:0] a_x, a_u, a_t;
  always_comb begin
    if (!pass_r) begin
      a_u = bwd_r ? {i_r, k_r} : {k_r, i_r};
      a_x = {k_r, j_r};
    end else begin
      a_u = bwd_r ? {j_r, k_r} : {k_r, j_r};
      a_x = {k_r, j_r};
    end
    a_t = {i_r, k_r};
  end

  logic [DataW-1:0] x_q, u_q, t_q;
  logic             t_we;
  logic [AddrW-1:0] t_wa;
  logic [DataW-1:0] t_wd;

  ost_ram #(.Width(DataW), .Depth(MaxDim*MaxDim)) u_xram (
    .clk(clk), .we(accept && in_mode == MODE_WR_X), .waddr({in_row, in_col}),
    .wdata(in_value), .raddr(a_x), .rdata(x_q));
  ost_ram #(.Width(DataW), .Depth(MaxDim*MaxDim)) u_uram (
    .clk(clk), .we(accept && in_mode == MODE_WR_U), .waddr({in_row, in_col}),
    .wdata(in_value), .raddr(a_u), .rdata(u_q));
  ost_ram #(.Width(DataW), .Depth(MaxDim*MaxDim)) u_tram (
    .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(a_t), .rdata(t_q));

  // Pass 1 reads T. A T element is written once its last term has passed the tag
  // register and the three cells and can be read after that, which only matters
  // at n=1; pass 1 always waits out the gap after the last pass 0 term.
  assign stall = (gap_r != '0);

  // Sequencer.
  logic  last_term;
  assign last_term = (k_r == n1) && (j_r == n1) && (i_r == n1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept && in_mode == MODE_RUN) state_nxt = ST_RUN;
      ST_RUN:   if (pass_r && last_term && !stall) state_nxt = ST_DRAIN;
      ST_DRAIN: if (drain_r == 4'd0) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pass_r  <= 1'b0;
      i_r <= '0; j_r <= '0; k_r <= '0;
      drain_r <= '0;
      gap_r   <= '0;
      bwd_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE && accept && in_mode == MODE_RUN) begin
        bwd_r  <= in_backward;
        pass_r <= 1'b0;
        gap_r  <= '0;
        i_r <= '0; j_r <= '0; k_r <= '0;
      end else if (state_r == ST_RUN) begin
        if (stall) begin
          gap_r <= gap_r - 3'd1;
        end else if (k_r != n1) begin
          k_r <= k_r + 1'b1;
        end else begin
          k_r <= '0;
          if (j_r != n1) begin
            j_r <= j_r + 1'b1;
          end else begin
            j_r <= '0;
            if (i_r != n1) begin
              i_r <= i_r + 1'b1;
            end else begin
              i_r    <= '0;
              pass_r <= 1'b1;
              gap_r  <= 3'd4;
            end
          end
        end
        drain_r <= 4'd8;
      end else if (state_r == ST_DRAIN) begin
        drain_r <= drain_r - 4'd1;
      end
    end
  end

  // Tag for the term issued now; the RAM data is ready in the next cycle.
  tag_t tag_iss, tag_rd_r;
  always_comb begin
    tag_iss.vld   = (state_r == ST_RUN);
    tag_iss.first = (k_r == '0);
    tag_iss.fin   = (k_r == n1);
    tag_iss.emit  = pass_r;
    tag_iss.row   = i_r;
    tag_iss.col   = j_r;
    tag_iss.lst   = pass_r && last_term;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_rd_r <= '0;
    end else begin
      tag_rd_r <= stall ? '0 : tag_iss;
    end
  end

  logic signed [63:0] prod;
  logic               pass_d_r;
  always_ff @(posedge clk) begin
    pass_d_r <= pass_r;
  end
  always_comb begin
    if (!pass_d_r) begin
      prod = $signed(u_q) * $signed(x_q);
    end else begin
      prod = $signed(t_q) * $signed(u_q);
    end
  end

  tag_t               tg0, tg1, tg2;
  logic signed [63:0] d0, d1, d2;
  ost_cell u_c0 (.clk(clk), .rst_n(rst_n), .sel(2'd0), .tag_in(tag_rd_r),
                 .din(prod), .tag_out(tg0), .dout(d0));
  ost_cell u_c1 (.clk(clk), .rst_n(rst_n), .sel(2'd1), .tag_in(tg0),
                 .din(d0), .tag_out(tg1), .dout(d1));
  ost_cell u_c2 (.clk(clk), .rst_n(rst_n), .sel(2'd2), .tag_in(tg1),
                 .din(d1), .tag_out(tg2), .dout(d2));

  // T written as soon as its sum completes.
  assign t_we = tg2.vld && tg2.fin && !tg2.emit;
  assign t_wa = {tg2.row, tg2.col};
  assign t_wd = d2[DataW-1:0];

  assign out_strobe = tg2.vld && tg2.fin && tg2.emit;
  assign out_row    = tg2.row;
  assign out_col    = tg2.col;
  assign out_value  = d2[DataW-1:0];
  assign out_last   = tg2.lst;
endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for orthogonal_similarity_transform
// Loads X and U element by element, runs forward and backward transforms
// at several sizes, and checks each emitted element against an in-bench
// fixed-point predictor.
// ----------------------------------------------------------------------------
module testbench;
  import ost_pkg::*;

  localparam int CycleLimit = 600000;

  typedef struct {
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] value;
    logic               last;
  } elem_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  mode_t              in_mode = MODE_NOP;
  logic [2:0]         in_row = '0;
  logic [2:0]         in_col = '0;
  logic signed [31:0] in_value = '0;
  logic               in_backward = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [3:0]         cfg_data = '0;
  logic               out_strobe;
  logic [2:0]         out_row;
  logic [2:0]         out_col;
  logic signed [31:0] out_value;
  logic               out_last;

  // predictor state: copies of both stores and the size register
  logic signed [DataW-1:0] x_mem [MaxDim*MaxDim];
  logic signed [DataW-1:0] u_mem [MaxDim*MaxDim];
  bit                      x_set [MaxDim*MaxDim];
  bit                      u_set [MaxDim*MaxDim];
  logic [3:0]              size_reg = 4'd8;

  elem_t pending_q[$];
  int    mismatches = 0;
  int    cycles = 0;
  int    items_sent = 0;
  int    burst_left = 0;

  orthogonal_similarity_transform uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_row(in_row), .in_col(in_col),
    .in_value(in_value), .in_backward(in_backward),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_strobe(out_strobe), .out_row(out_row), .out_col(out_col),
    .out_value(out_value), .out_last(out_last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Q15.16 product, round to nearest, ties up
  function automatic logic signed [63:0] round_mul(logic signed [31:0] a,
                                                   logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // size 0 behaves as 1, anything above the built max as the max
  function automatic int dim_of(logic [3:0] s);
    if (s == 0) return 1;
    if (s > MaxDim) return MaxDim;
    return s;
  endfunction

  // Forms T first, then the product, and queues the n*n elements in order.
  task automatic predict_transform(bit bwd);
    logic signed [31:0] t [MaxDim*MaxDim];
    logic signed [63:0] acc;
    logic signed [31:0] u;
    elem_t              e;
    int                 n;
    n = dim_of(size_reg);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = 0;
        for (int k = 0; k < n; k++) begin
          u = bwd ? u_mem[i*MaxDim+k] : u_mem[k*MaxDim+i];
          acc += round_mul(u, x_mem[k*MaxDim+j]);
        end
        t[i*MaxDim+j] = clamp32(acc);
      end
    end
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = 0;
        for (int k = 0; k < n; k++) begin
          u = bwd ? u_mem[j*MaxDim+k] : u_mem[k*MaxDim+j];
          acc += round_mul(t[i*MaxDim+k], u);
        end
        e.row = 3'(i);
        e.col = 3'(j);
        e.value = clamp32(acc);
        e.last = (i == n-1) && (j == n-1);
        pending_q.push_back(e);
      end
    end
  endtask

  // Result checker: strobe is sampled at the edge that accepts the element.
  always @(posedge clk) begin
    elem_t e;
    if (rst_n && out_strobe) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected element r%0d c%0d v%0d", out_row, out_col, out_value);
      end else begin
        e = pending_q.pop_front();
        if (out_row !== e.row || out_col !== e.col || out_value !== e.value ||
            out_last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("element mismatch: exp r%0d c%0d v%0d l%0d, got r%0d c%0d v%0d l%0d",
                     e.row, e.col, e.value, e.last,
                     out_row, out_col, out_value, out_last);
        end
      end
    end
  end

  task automatic idle_for(int k);
    start <= 1'b0;
    repeat (k) @(negedge clk);
  endtask

  // Sends one item. Called at a falling edge; start is left high so that
  // back-to-back items need no extra assignment.
  task automatic send_item(mode_t m, int r, int c, logic signed [31:0] v, bit bwd);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 6));
    end
    burst_left--;
    start <= 1'b1;
    in_mode <= m;
    in_row <= 3'(r);
    in_col <= 3'(c);
    in_value <= v;
    in_backward <= bwd;
    // busy only moves at rising edges, so its value here holds at the next one
    while (busy) @(negedge clk);
    @(negedge clk);
    items_sent++;
    case (m)
      MODE_WR_X: begin
        x_mem[r*MaxDim+c] = v;
        x_set[r*MaxDim+c] = 1;
      end
      MODE_WR_U: begin
        u_mem[r*MaxDim+c] = v;
        u_set[r*MaxDim+c] = 1;
      end
      MODE_RUN: predict_transform(bwd);
      default: ;
    endcase
  endtask

  // drain results, then a few cycles for any load still settling
  task automatic wait_idle();
    start <= 1'b0;
    @(negedge clk);
    while (pending_q.size() != 0 || busy) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_size(logic [3:0] s);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= s;
    while (!cfg_ready) @(negedge clk);
    @(negedge clk);
    size_reg = s;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      3: return ($urandom_range(0, 1) ? 32'sh00010000 : -32'sh00010000);
      default: return $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
    endcase
  endfunction

  // fills every element of the active n by n corner that a run will read
  task automatic load_corner(int n, bit refresh);
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        if (!x_set[r*MaxDim+c] || (refresh && $urandom_range(0, 1)))
          send_item(MODE_WR_X, r, c, rand_q(), 0);
        if (!u_set[r*MaxDim+c] || (refresh && $urandom_range(0, 1)))
          send_item(MODE_WR_U, r, c, rand_q(), 0);
      end
    end
  endtask

  // one element, identity and full-scale values, both directions
  task automatic test_single_element();
    write_size(4'd1);
    send_item(MODE_WR_X, 0, 0, 32'sh7fffffff, 0);
    send_item(MODE_WR_U, 0, 0, 32'sh00010000, 0);
    send_item(MODE_RUN, 0, 0, 0, 0);
    send_item(MODE_WR_U, 0, 0, 32'sh80000000, 0);
    send_item(MODE_RUN, 7, 7, 32'sh7fffffff, 1);
  endtask

  // size 0 acts as 1; 2x2 with extreme values drives both saturation sides
  task automatic test_saturation();
    write_size(4'd0);
    send_item(MODE_RUN, 0, 0, 0, 1);
    write_size(4'd2);
    send_item(MODE_WR_X, 0, 1, 32'sh80000000, 0);
    send_item(MODE_WR_X, 1, 0, 32'sh7fffffff, 0);
    send_item(MODE_WR_X, 1, 1, 32'sh80000000, 0);
    send_item(MODE_WR_U, 0, 1, 32'sh7fffffff, 0);
    send_item(MODE_WR_U, 1, 0, 32'sh80000000, 0);
    send_item(MODE_WR_U, 1, 1, 32'sh7fffffff, 0);
    send_item(MODE_RUN, 0, 0, 0, 0);
    send_item(MODE_RUN, 0, 0, 0, 1);
  endtask

  // unused mode, writes outside the active corner, far-corner indexes
  task automatic test_nop_and_rewrites();
    send_item(MODE_NOP, 7, 7, 32'sh7fffffff, 1);
    send_item(MODE_WR_X, 7, 7, 32'sh80000000, 0);
    send_item(MODE_WR_U, 7, 0, 32'sh00010000, 0);
    send_item(MODE_NOP, 0, 0, 0, 0);
    send_item(MODE_RUN, 0, 0, 0, 0);
  endtask

  // random phases: new size, fill or refresh the corner, noise, then runs
  task automatic test_random_phases();
    int  n;
    bit  did_full;
    logic [3:0] s;
    did_full = 0;
    while (items_sent < 165) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: n = $urandom_range(1, 3);
        4, 5, 6, 7, 8: n = $urandom_range(3, 5);
        default: n = did_full ? $urandom_range(1, 4) : 8;
      endcase
      if (n == 8) did_full = 1;
      s = 4'(n);
      if (n == 1 && $urandom_range(0, 1)) s = 4'd0;
      if (n == 8 && $urandom_range(0, 1)) s = 4'($urandom_range(9, 15));
      write_size(s);
      load_corner(n, 1);
      repeat ($urandom_range(0, 3)) begin
        case ($urandom_range(0, 2))
          0: send_item(MODE_WR_X, $urandom_range(0, 7), $urandom_range(0, 7), rand_q(), 0);
          1: send_item(MODE_WR_U, $urandom_range(0, 7), $urandom_range(0, 7), rand_q(), 0);
          default: send_item(MODE_NOP, $urandom_range(0, 7), $urandom_range(0, 7),
                             $urandom, $urandom_range(0, 1));
        endcase
      end
      load_corner(n, 0);
      repeat ($urandom_range(1, 2))
        send_item(MODE_RUN, $urandom_range(0, 7), $urandom_range(0, 7), $urandom,
                  $urandom_range(0, 1));
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_single_element();
    test_saturation();
    test_nop_and_rewrites();
    test_random_phases();
    wait_idle();
    repeat (40) @(negedge clk);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
